// ----- rtl/srp_pkg.sv -----
`default_nettype none
package srp_pkg;
	localparam int unsigned ReqBits = 12;
	localparam int unsigned CfgBits = 13;
	localparam int unsigned CfgIdxBits = 1;
	localparam logic [CfgIdxBits-1:0] RegAtlasWidth = 1'd0;
	localparam logic [CfgIdxBits-1:0] RegAtlasHeight = 1'd1;

	typedef enum logic [1:0] {
		ST_PLACED = 2'd0,
		ST_ATLAS_FULL = 2'd1,
		ST_STORE_FULL = 2'd2
	} place_status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIT_START,
		S_FIT_HEAD,
		S_FIT_WALK,
		S_FIT_DONE,
		S_DECIDE,
		S_COPY_START,
		S_COPY,
		S_RESULT
	} ctrl_state_t;

	typedef struct packed {
		logic load_req;
		logic fit_start;
		logic fit_head;
		logic fit_step;
		logic fit_done;
		logic result_fail;
		logic copy_start;
		logic copy_step;
		logic copy_fin;
		logic set_result;
	} dp_cmd_t;

	typedef struct packed {
		logic fit_end;
		logic fit_more_seg;
		logic found;
		logic store_full;
		logic copy_end;
	} dp_stat_t;
endpackage
`default_nettype wire

// ----- rtl/srp_req_if.sv -----
`default_nettype none
interface srp_req_if;
	logic valid;
	logic ready;
	logic [11:0] req_width;
	logic [11:0] req_height;
	modport source (output valid, output req_width, output req_height, input ready);
	modport sink (input valid, input req_width, input req_height, output ready);
endinterface
`default_nettype wire

// ----- rtl/srp_res_if.sv -----
`default_nettype none
interface srp_res_if;
	logic valid;
	logic ready;
	logic [11:0] place_x;
	logic [11:0] place_y;
	logic [1:0] status;
	modport source (output valid, output place_x, output place_y, output status, input ready);
	modport sink (input valid, input place_x, input place_y, input status, output ready);
endinterface
`default_nettype wire

// ----- rtl/srp_ctrl.sv -----
`default_nettype none
module srp_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_fire,
	input  wire logic res_busy,
	input  wire srp_pkg::dp_stat_t stat,
	output srp_pkg::dp_cmd_t cmd,
	output logic ready
);
	import srp_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (req_fire) state_d = S_FIT_START;
			S_FIT_START: state_d = S_FIT_HEAD;
			S_FIT_HEAD: state_d = S_FIT_WALK;
			S_FIT_WALK: if (stat.fit_end) state_d = S_FIT_DONE;
			S_FIT_DONE: state_d = stat.fit_more_seg ? S_FIT_START : S_DECIDE;
			S_DECIDE: begin
				if (!stat.found || stat.store_full) state_d = S_RESULT;
				else state_d = S_COPY_START;
			end
			S_COPY_START: state_d = S_COPY;
			S_COPY: if (stat.copy_end) state_d = S_RESULT;
			S_RESULT: if (!res_busy) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				ready = 1'b1;
				cmd.load_req = req_fire;
			end
			S_FIT_START: cmd.fit_start = 1'b1;
			S_FIT_HEAD: cmd.fit_head = 1'b1;
			S_FIT_WALK: cmd.fit_step = !stat.fit_end;
			S_FIT_DONE: cmd.fit_done = 1'b1;
			S_DECIDE: cmd.result_fail = !stat.found || stat.store_full;
			S_COPY_START: cmd.copy_start = 1'b1;
			S_COPY: begin
				cmd.copy_step = !stat.copy_end;
				cmd.copy_fin = stat.copy_end;
			end
			S_RESULT: cmd.set_result = !res_busy;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ----- rtl/srp_datapath.sv -----
`default_nettype none
module srp_datapath #(
	parameter int unsigned MAX_SEGMENTS = 64,
	parameter int unsigned COORD_BITS = 12
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire srp_pkg::dp_cmd_t cmd,
	output srp_pkg::dp_stat_t stat,
	input  wire logic cfg_we,
	input  wire logic [srp_pkg::CfgIdxBits-1:0] cfg_idx,
	input  wire logic [srp_pkg::CfgBits-1:0] cfg_data,
	input  wire logic [srp_pkg::ReqBits-1:0] req_width,
	input  wire logic [srp_pkg::ReqBits-1:0] req_height,
	output logic [srp_pkg::ReqBits-1:0] place_x,
	output logic [srp_pkg::ReqBits-1:0] place_y,
	output srp_pkg::place_status_t status,
	output logic res_load
);
	import srp_pkg::*;

	localparam int unsigned IB = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int unsigned CB = $clog2(MAX_SEGMENTS + 1);
	localparam int unsigned AB = IB + 1;
	// value width: coordinates up to 2^COORD_BITS plus padded sums
	localparam int unsigned VB = ((COORD_BITS > ReqBits) ? COORD_BITS : ReqBits) + 3;
	localparam logic [VB-1:0] DimLim = VB'(1) << COORD_BITS;

	typedef struct packed {
		logic [VB-1:0] x;
		logic [VB-1:0] y;
		logic [VB-1:0] w;
	} seg_t;

	// two banks in one memory: a placement streams the live bank into the
	// spare one, then the banks swap
	seg_t seg_mem [2**AB];
	seg_t rd_q;
	logic rd_en, wr_en;
	logic [AB-1:0] rd_addr, wr_addr;
	seg_t wr_data;

	logic [CfgBits-1:0] aw_cfg_q, ah_cfg_q;
	logic [VB-1:0] aw, ah;
	assign aw = ({{(VB-CfgBits){1'b0}}, aw_cfg_q} > DimLim) ? DimLim
		: VB'(aw_cfg_q);
	assign ah = ({{(VB-CfgBits){1'b0}}, ah_cfg_q} > DimLim) ? DimLim
		: VB'(ah_cfg_q);

	logic reinit_q, bank_q;
	logic [CB-1:0] count_q;
	logic [VB-1:0] w_q, h_q;
	logic [CB-1:0] k_q, i_q, best_q, j_q, wp_q;
	logic [VB-1:0] fy_q, left_q, kx_q, kw_q;
	logic fit_ok_q, fit_fin_q, found_q;
	logic [VB-1:0] best_top_q, best_w_q, bx_q, by_q, end_q;
	logic ins_q, trim_on_q, acc_v_q;
	seg_t acc_q;

	// fit walk step on the entry held in rd_q
	logic [VB-1:0] ny, cand_top;
	assign ny = (rd_q.y > fy_q) ? rd_q.y : fy_q;
	assign cand_top = fy_q + h_q;

	// rebuild stream: old entries with the new segment slotted in at best,
	// followers under the new segment trimmed or dropped
	logic take_new, take_old, elem_v, acc_hit;
	logic [VB-1:0] shrink;
	seg_t elem;
	always_comb begin
		take_new = !ins_q && (j_q == best_q);
		take_old = !take_new && (j_q < count_q);
		shrink = end_q - rd_q.x;
		elem = rd_q;
		elem_v = take_old;
		if (take_new) begin
			elem.x = bx_q;
			elem.y = by_q + h_q;
			elem.w = w_q;
			elem_v = 1'b1;
		end else if (ins_q && trim_on_q && rd_q.x < end_q) begin
			if (rd_q.w <= shrink) begin
				elem_v = 1'b0;
			end else begin
				elem.x = end_q;
				elem.w = rd_q.w - shrink;
			end
		end
	end
	// equal heights coalesce into the pending output entry
	assign acc_hit = acc_v_q && (acc_q.y == elem.y);

	logic [VB-1:0] iw;
	always_comb begin
		iw = aw - VB'(2);
		if (aw < VB'(2)) iw = '0;
	end

	assign stat.fit_end = fit_fin_q;
	assign stat.fit_more_seg = (k_q + CB'(1)) < count_q;
	assign stat.found = found_q;
	assign stat.store_full = count_q >= CB'(MAX_SEGMENTS);
	assign stat.copy_end = ins_q && (j_q >= count_q);
	assign res_load = cmd.set_result;

	// read port
	always_comb begin
		rd_en = 1'b0;
		rd_addr = {bank_q, k_q[IB-1:0]};
		if (cmd.fit_start) begin
			rd_en = 1'b1;
			rd_addr = {bank_q, k_q[IB-1:0]};
		end else if (cmd.fit_step) begin
			rd_en = 1'b1;
			rd_addr = {bank_q, IB'(i_q + CB'(1))};
		end else if (cmd.copy_start) begin
			rd_en = 1'b1;
			rd_addr = {bank_q, IB'(0)};
		end else if (cmd.copy_step && take_old) begin
			rd_en = 1'b1;
			rd_addr = {bank_q, IB'(j_q + CB'(1))};
		end
	end

	// write port
	always_comb begin
		wr_en = 1'b0;
		wr_addr = {!bank_q, wp_q[IB-1:0]};
		wr_data = acc_q;
		if (reinit_q) begin
			wr_en = 1'b1;
			wr_addr = {bank_q, IB'(0)};
			wr_data.x = VB'(1);
			wr_data.y = VB'(1);
			wr_data.w = iw;
		end else if (cmd.copy_step && elem_v && acc_v_q && !acc_hit) begin
			wr_en = 1'b1;
		end else if (cmd.copy_fin) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) seg_mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= seg_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aw_cfg_q <= CfgBits'(512);
			ah_cfg_q <= CfgBits'(512);
			reinit_q <= 1'b1;
			bank_q <= 1'b0;
			count_q <= CB'(1);
			w_q <= '0;
			h_q <= '0;
			k_q <= '0;
			i_q <= '0;
			best_q <= '0;
			j_q <= '0;
			wp_q <= '0;
			fy_q <= '0;
			left_q <= '0;
			kx_q <= '0;
			kw_q <= '0;
			fit_ok_q <= 1'b0;
			fit_fin_q <= 1'b0;
			found_q <= 1'b0;
			best_top_q <= '0;
			best_w_q <= '0;
			bx_q <= '0;
			by_q <= '0;
			end_q <= '0;
			ins_q <= 1'b0;
			trim_on_q <= 1'b0;
			acc_v_q <= 1'b0;
			acc_q <= '0;
		end else begin
			reinit_q <= 1'b0;
			if (cfg_we && cfg_idx == RegAtlasWidth) begin
				aw_cfg_q <= cfg_data;
				reinit_q <= 1'b1;
			end
			if (cfg_we && cfg_idx == RegAtlasHeight) ah_cfg_q <= cfg_data;
			if (reinit_q) count_q <= CB'(1);
			if (cmd.load_req) begin
				w_q <= VB'(req_width) + VB'(2);
				h_q <= VB'(req_height) + VB'(2);
				found_q <= 1'b0;
				k_q <= '0;
			end
			if (cmd.fit_start) i_q <= k_q;
			if (cmd.fit_head) begin
				kx_q <= rd_q.x;
				kw_q <= rd_q.w;
				fy_q <= rd_q.y;
				left_q <= w_q;
				fit_ok_q <= (rd_q.x + w_q) < aw;
				fit_fin_q <= !((rd_q.x + w_q) < aw);
			end
			if (cmd.fit_step) begin
				if (i_q >= count_q || (ny + h_q) >= ah) begin
					fit_ok_q <= 1'b0;
					fit_fin_q <= 1'b1;
				end else begin
					fy_q <= ny;
					i_q <= i_q + CB'(1);
					if (left_q <= rd_q.w) fit_fin_q <= 1'b1;
					left_q <= left_q - rd_q.w;
				end
			end
			if (cmd.fit_done) begin
				fit_fin_q <= 1'b0;
				if (fit_ok_q && (!found_q || cand_top < best_top_q ||
				    (cand_top == best_top_q && kw_q != '0 && kw_q < best_w_q))) begin
					found_q <= 1'b1;
					best_top_q <= cand_top;
					best_w_q <= kw_q;
					best_q <= k_q;
					bx_q <= kx_q;
					by_q <= fy_q;
				end
				k_q <= k_q + CB'(1);
			end
			if (cmd.copy_start) begin
				j_q <= '0;
				wp_q <= '0;
				ins_q <= 1'b0;
				trim_on_q <= 1'b1;
				acc_v_q <= 1'b0;
			end
			if (cmd.copy_step) begin
				if (take_new) begin
					ins_q <= 1'b1;
					end_q <= bx_q + w_q;
				end else begin
					j_q <= j_q + CB'(1);
					// trimming stops at the first follower that survives
					if (ins_q && !(rd_q.x < end_q && rd_q.w <= shrink)) trim_on_q <= 1'b0;
				end
				if (elem_v) begin
					if (acc_hit) begin
						acc_q.w <= acc_q.w + elem.w;
					end else begin
						acc_q <= elem;
						acc_v_q <= 1'b1;
						if (acc_v_q) wp_q <= wp_q + CB'(1);
					end
				end
			end
			if (cmd.copy_fin) begin
				count_q <= wp_q + CB'(1);
				bank_q <= !bank_q;
			end
		end
	end

	// result fields
	logic fail_q;
	logic [1:0] fail_code_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_q <= 1'b0;
			fail_code_q <= '0;
		end else begin
			if (cmd.load_req) fail_q <= 1'b0;
			if (cmd.result_fail) begin
				fail_q <= 1'b1;
				fail_code_q <= found_q ? ST_STORE_FULL : ST_ATLAS_FULL;
			end
		end
	end

	logic [VB-1:0] ox, oy;
	assign ox = bx_q + VB'(1);
	assign oy = by_q + VB'(1);
	always_comb begin
		if (fail_q) begin
			place_x = '0;
			place_y = '0;
			status = place_status_t'(fail_code_q);
		end else begin
			place_x = ReqBits'(ox & ((VB'(1) << COORD_BITS) - VB'(1)));
			place_y = ReqBits'(oy & ((VB'(1) << COORD_BITS) - VB'(1)));
			status = ST_PLACED;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/skyline_rect_packer_unit.sv -----
`default_nettype none
// Skyline bottom-left rectangle packer. Each request is padded by one pixel
// on every side and placed at the lowest top edge found over all skyline
// segments; one result per request. The block takes one request at a time
// and keeps the skyline in a two-bank memory with one registered read and
// one write per cycle. For each segment the scan reads its head entry and
// then walks over the segments that the fit spans (none when the right
// edge already fails). A placement then streams the skyline into the spare
// bank, inserting, trimming and merging on the way; nothing is streamed
// when nothing is placed. A finished result waits in the output register,
// so one further request can be worked on while the result side holds off.
// Writing atlas_width resets the skyline.
module skyline_rect_packer_unit #(
	parameter int unsigned MAX_SEGMENTS = 64,
	parameter int unsigned COORD_BITS = 12
) (
	input  wire logic clk,
	input  wire logic arst_n,
	srp_req_if.sink req,
	srp_res_if.source res,
	input  wire logic cfg_we,
	input  wire logic [srp_pkg::CfgIdxBits-1:0] cfg_idx,
	input  wire logic [srp_pkg::CfgBits-1:0] cfg_data
);
	import srp_pkg::*;

	dp_cmd_t cmd;
	dp_stat_t stat;
	logic ready_c, res_load;
	logic [ReqBits-1:0] px, py;
	place_status_t st;

	// output register decouples the result from the controller
	logic res_valid_q;
	logic [ReqBits-1:0] res_x_q, res_y_q;
	logic [1:0] res_st_q;

	assign req.ready = ready_c;

	srp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.req_fire(req.valid && ready_c),
		.res_busy(res_valid_q && !res.ready),
		.stat(stat), .cmd(cmd), .ready(ready_c)
	);

	srp_datapath #(.MAX_SEGMENTS(MAX_SEGMENTS), .COORD_BITS(COORD_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.req_width(req.req_width), .req_height(req.req_height),
		.place_x(px), .place_y(py), .status(st), .res_load(res_load)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid_q <= 1'b0;
		else if (res_load) res_valid_q <= 1'b1;
		else if (res.ready) res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_x_q <= px;
			res_y_q <= py;
			res_st_q <= st;
		end
	end

	assign res.valid = res_valid_q;
	assign res.place_x = res_x_q;
	assign res.place_y = res_y_q;
	assign res.status = res_st_q;
endmodule
`default_nettype wire

// ----- dv/srp_placement_checker.sv -----
`timescale 1ns / 1ps
module srp_placement_checker (
	input wire logic clk,
	input wire logic arst_n,
	srp_req_if req,
	srp_res_if res,
	input wire logic cfg_we,
	input wire logic [srp_pkg::CfgIdxBits-1:0] cfg_idx,
	input wire logic [srp_pkg::CfgBits-1:0] cfg_data,
	output int mismatches
);
	import srp_pkg::*;

	localparam int MaxSeg = 64;
	localparam int DimCap = 4096;

	typedef struct {
		logic [11:0] x;
		logic [11:0] y;
		place_status_t status;
	} placement_t;

	placement_t pending_q[$];
	int atlas_w, atlas_h;
	int sky_x[MaxSeg+1], sky_y[MaxSeg+1], sky_w[MaxSeg+1];
	int sky_n;

	function automatic int clamp_dim(int v);
		return (v > DimCap) ? DimCap : v;
	endfunction

	function automatic void reset_skyline();
		int w;
		w = clamp_dim(atlas_w) - 2;
		sky_x[0] = 1;
		sky_y[0] = 1;
		sky_w[0] = (w < 0) ? 0 : w;
		sky_n = 1;
	endfunction

	function automatic void drop_segment(int k);
		for (int j = k; j + 1 < sky_n; j++) begin
			sky_x[j] = sky_x[j+1];
			sky_y[j] = sky_y[j+1];
			sky_w[j] = sky_w[j+1];
		end
		sky_n--;
	endfunction

	// lowest floor for a w x h box starting at segment k, -1 if none
	function automatic int floor_at(int k, int w, int h);
		int y, left, i;
		y = sky_y[k];
		left = w;
		i = k;
		if (sky_x[k] + w >= clamp_dim(atlas_w))
			return -1;
		while (left > 0) begin
			if (i >= sky_n)
				return -1;
			if (sky_y[i] > y)
				y = sky_y[i];
			if (y + h >= clamp_dim(atlas_h))
				return -1;
			left -= sky_w[i];
			i++;
		end
		return y;
	endfunction

	function automatic placement_t place_glyph(logic [11:0] rw, logic [11:0] rh);
		placement_t p;
		int w, h, y, best_top, best_w, best, bx, by, i, seg_end, shrink;
		bit found;
		w = int'(rw) + 2;
		h = int'(rh) + 2;
		found = 0;
		best_top = 0; best_w = 0; best = 0; bx = 0; by = 0;
		p.x = '0;
		p.y = '0;
		for (i = 0; i < sky_n; i++) begin
			y = floor_at(i, w, h);
			if (y < 0)
				continue;
			if (!found || y + h < best_top ||
			    (y + h == best_top && sky_w[i] > 0 && sky_w[i] < best_w)) begin
				found = 1;
				best_top = y + h;
				best_w = sky_w[i];
				best = i;
				bx = sky_x[i];
				by = y;
			end
		end
		if (!found) begin
			p.status = ST_ATLAS_FULL;
			return p;
		end
		if (sky_n >= MaxSeg) begin
			p.status = ST_STORE_FULL;
			return p;
		end
		for (i = sky_n; i > best; i--) begin
			sky_x[i] = sky_x[i-1];
			sky_y[i] = sky_y[i-1];
			sky_w[i] = sky_w[i-1];
		end
		sky_x[best] = bx;
		sky_y[best] = by + h;
		sky_w[best] = w;
		sky_n++;
		// followers under the new segment get trimmed or dropped
		i = best + 1;
		while (i < sky_n) begin
			seg_end = sky_x[i-1] + sky_w[i-1];
			if (sky_x[i] >= seg_end)
				break;
			shrink = seg_end - sky_x[i];
			if (sky_w[i] - shrink <= 0) begin
				drop_segment(i);
			end else begin
				sky_x[i] += shrink;
				sky_w[i] -= shrink;
				break;
			end
		end
		i = 0;
		while (i + 1 < sky_n) begin
			if (sky_y[i] == sky_y[i+1]) begin
				sky_w[i] += sky_w[i+1];
				drop_segment(i + 1);
			end else begin
				i++;
			end
		end
		p.x = 12'(bx + 1);
		p.y = 12'(by + 1);
		p.status = ST_PLACED;
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		placement_t want;
		if (!arst_n) begin
			atlas_w = 512;
			atlas_h = 512;
			reset_skyline();
			pending_q.delete();
			mismatches = 0;
		end else begin
			if (res.valid && res.ready) begin
				if (pending_q.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected placement x=%0d y=%0d status=%0d",
						$time, res.place_x, res.place_y, res.status);
				end else begin
					want = pending_q.pop_front();
					if (res.place_x !== want.x || res.place_y !== want.y ||
					    res.status !== want.status) begin
						mismatches++;
						$display("%0t: placement mismatch expected x=%0d y=%0d status=%0d, got x=%0d y=%0d status=%0d",
							$time, want.x, want.y, want.status,
							res.place_x, res.place_y, res.status);
					end
				end
			end
			if (cfg_we) begin
				if (cfg_idx == RegAtlasWidth) begin
					atlas_w = int'(cfg_data);
					reset_skyline();
				end else if (cfg_idx == RegAtlasHeight) begin
					atlas_h = int'(cfg_data);
				end
			end
			if (req.valid && req.ready)
				pending_q.insert(pending_q.size(),
					place_glyph(req.req_width, req.req_height));
		end
	end
endmodule

// ----- dv/skyline_rect_packer_unit_test.sv -----
`timescale 1ns / 1ps
module skyline_rect_packer_unit_test;
	import srp_pkg::*;

	localparam int WatchdogLimit = 40000;
	localparam int HoldCycles = 3000;
	localparam int Chunks = 12;
	localparam int ChunkItems = 76;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CfgIdxBits-1:0] cfg_idx = RegAtlasWidth;
	logic [CfgBits-1:0] cfg_data = '0;
	int mismatches;

	srp_req_if req ();
	srp_res_if res ();

	// idle odds in percent for each side, set per phase
	int send_idle_pct = 9;
	int recv_idle_pct = 55;
	int sent = 0;
	int placed_back = 0;
	int hold_left = 0;
	bit held = 0;
	int quiet = 0;

	always #2 clk = ~clk;

	skyline_rect_packer_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.res(res),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	srp_placement_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.res(res),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.mismatches(mismatches)
	);

	initial begin
		req.valid = 1'b0;
		req.req_width = '0;
		req.req_height = '0;
		res.ready = 1'b0;
	end

	// result side: random back-pressure plus one long hold-off so the block
	// sits on a finished result while the sender keeps a request waiting
	always @(posedge clk) begin
		if (res.valid && res.ready)
			placed_back <= placed_back + 1;
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res.ready <= 1'b0;
		end else if (!held && placed_back == 150) begin
			held <= 1'b1;
			hold_left <= HoldCycles;
			res.ready <= 1'b0;
		end else begin
			res.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// watchdog: cycles with no request and no result moving
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (res.valid && res.ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= WatchdogLimit) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic send_request(input logic [11:0] w, input logic [11:0] h);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.req_width <= w;
		req.req_height <= h;
		do @(posedge clk); while (!req.ready);
		sent++;
	endtask

	// let every outstanding placement drain before touching the registers
	task automatic drain();
		req.valid <= 1'b0;
		while (placed_back != sent) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_atlas(input int w, input int h);
		cfg_we <= 1'b1;
		cfg_idx <= RegAtlasWidth;
		cfg_data <= CfgBits'(w);
		@(posedge clk);
		cfg_idx <= RegAtlasHeight;
		cfg_data <= CfgBits'(h);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// mostly small glyphs so the skyline fills in many segments, some wide
	// ones and some with every bit of the field in play
	task automatic random_request();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			send_request(12'($urandom_range(0, 40)), 12'($urandom_range(0, 40)));
		else if (pick < 90)
			send_request(12'($urandom_range(0, 300)), 12'($urandom_range(0, 300)));
		else if (pick < 98)
			send_request(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
		else
			send_request('0, '0);
	endtask

	// narrow glyphs of rising height: each lands beside the last, so the
	// skyline grows one segment per request until the store runs out
	task automatic fill_store(input int count);
		for (int i = 0; i < count; i++)
			send_request(12'($urandom_range(0, 3)), 12'(i + 1));
	endtask

	initial begin
		int widths[8];
		int heights[8];
		int k;
		widths = '{512, 4096, 8191, 300, 3, 1000, 64, 2000};
		heights = '{512, 8191, 300, 4096, 40, 3, 2000, 700};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: field extremes on the reset atlas
		send_request(12'd0, 12'd0);
		send_request(12'd4095, 12'd4095);
		send_request(12'd4093, 12'd4093);
		send_request(12'd508, 12'd0);
		send_request(12'd509, 12'd0);
		send_request(12'd0, 12'd509);
		send_request(12'haaa, 12'h555);
		send_request(12'h555, 12'haaa);
		drain();
		// oversized atlas gets clamped
		set_atlas(8191, 8191);
		send_request(12'd4093, 12'd0);
		send_request(12'd0, 12'd4093);
		send_request(12'd4092, 12'd4092);
		drain();
		// tiny atlases where nothing fits, then one with room for a single glyph
		set_atlas(0, 3);
		send_request(12'd0, 12'd0);
		drain();
		set_atlas(1, 4096);
		send_request(12'd0, 12'd0);
		drain();
		set_atlas(3, 3);
		send_request(12'd0, 12'd0);
		drain();
		set_atlas(4, 4);
		send_request(12'd0, 12'd0);
		send_request(12'd0, 12'd0);
		drain();
		// store full on a wide atlas
		set_atlas(4096, 4096);
		fill_store(68);
		drain();

		for (int c = 0; c < Chunks; c++) begin
			if (c < 4) begin
				send_idle_pct = 9;
				recv_idle_pct = 55;
			end else if (c < 8) begin
				send_idle_pct = 55;
				recv_idle_pct = 9;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			k = c % 8;
			set_atlas(widths[k], heights[k]);
			if (c % 3 == 1)
				fill_store(40);
			for (int i = 0; i < ChunkItems; i++)
				random_request();
			drain();
		end

		repeat (50) @(posedge clk);
		if (mismatches == 0 && placed_back == sent)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
